>>> sv/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk, off while rst_n is low.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Checked on every rising edge of clk, reset included.
`define ASSERT_CLK_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error(msg);

`endif

>>> sv/rgbdil_pkg.sv
package rgbdil_pkg;

    // Line buffer geometry
    localparam int MAX_WIDTH = 1024;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int IMG_W_W   = 11;
    localparam int IMG_H_W   = 16;
    localparam int EFF_W_W   = (COL_W + 1 > IMG_W_W) ? COL_W + 1 : IMG_W_W;

    // Pixel word: red, green, blue
    localparam int CH_W  = 8;
    localparam int PIX_W = 3 * CH_W;

    // Register reset values
    localparam logic [IMG_W_W-1:0] IMG_WIDTH_RST  = IMG_W_W'(640);
    localparam logic [IMG_H_W-1:0] IMG_HEIGHT_RST = IMG_H_W'(480);

    // Register index (paddr[2])
    localparam logic REG_IMG_WIDTH  = 1'b0;
    localparam logic REG_IMG_HEIGHT = 1'b1;

    // Input word codes
    localparam logic FUNC_PIXEL = 1'b0;
    localparam logic FUNC_FLUSH = 1'b1;

    // Output word buffer depth
    localparam int OFIFO_DEPTH = 4;
    localparam int OFIFO_AW    = $clog2(OFIFO_DEPTH);

    // Control word carried with an item through the line buffer stage
    typedef struct packed {
        logic valid;
        logic pix_op;
        logic emit;
        logic interior;
        logic frame_end;
    } s1_ctl_t;

    // One output word
    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic            frame_end;
    } result_t;

endpackage

>>> sv/rgbdil_ram.sv
module rgbdil_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/rgbdil_window.sv
module rgbdil_window (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           clear,
    input  logic                           rd_en,
    input  logic [rgbdil_pkg::COL_W-1:0]   rd_col,
    input  rgbdil_pkg::s1_ctl_t            ctl,
    input  logic [rgbdil_pkg::COL_W-1:0]   wr_col,
    input  logic [rgbdil_pkg::PIX_W-1:0]   pix,
    output logic                           push,
    output rgbdil_pkg::result_t            result
);

    localparam int PW = rgbdil_pkg::PIX_W;
    localparam int CW = rgbdil_pkg::CH_W;

    logic [PW-1:0]   window_reg [9];
    logic [PW-1:0]   window_next [9];
    logic [2*PW-1:0] line_rdata;
    logic [PW-1:0]   top_pix;
    logic [PW-1:0]   mid_pix;
    logic            line_we;
    logic [PW-1:0]   nbr [8];
    logic [PW-1:0]   best;

    function automatic logic [CW-1:0] max2(input logic [CW-1:0] a, input logic [CW-1:0] b);
        return (a > b) ? a : b;
    endfunction

    // Both lines share one word: upper row in the high half, middle row low
    rgbdil_ram #(
        .WIDTH (2 * PW),
        .DEPTH (rgbdil_pkg::MAX_WIDTH)
    ) u_lines (
        .clk   (clk),
        .we    (line_we),
        .waddr (wr_col),
        .wdata ({mid_pix, pix}),
        .re    (rd_en),
        .raddr (rd_col),
        .rdata (line_rdata)
    );

    assign top_pix = line_rdata[2*PW-1:PW];
    assign mid_pix = line_rdata[PW-1:0];
    assign line_we = ctl.valid && ctl.pix_op;

    // Window clears on clear; on a pixel it shifts left by one column, new column enters on the right
    always_comb
    begin
        for (int i = 0; i < 9; i++)
        begin
            window_next[i] = window_reg[i];
        end
        if (clear)
        begin
            for (int i = 0; i < 9; i++)
            begin
                window_next[i] = '0;
            end
        end
        else if (line_we)
        begin
            for (int k = 0; k < 3; k++)
            begin
                window_next[k*3]   = window_reg[k*3+1];
                window_next[k*3+1] = window_reg[k*3+2];
            end
            window_next[2] = top_pix;
            window_next[5] = mid_pix;
            window_next[8] = pix;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 9; i++)
            begin
                window_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < 9; i++)
            begin
                window_reg[i] <= window_next[i];
            end
        end
    end

    // Eight neighbours of the new window; the new center (old slot 5) is left out
    assign nbr[0] = window_reg[1];
    assign nbr[1] = window_reg[2];
    assign nbr[2] = top_pix;
    assign nbr[3] = window_reg[4];
    assign nbr[4] = mid_pix;
    assign nbr[5] = window_reg[7];
    assign nbr[6] = window_reg[8];
    assign nbr[7] = pix;

    // Per-channel max, three-level tree
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            best[c*CW +: CW] = max2(
                max2(max2(nbr[0][c*CW +: CW], nbr[1][c*CW +: CW]),
                     max2(nbr[2][c*CW +: CW], nbr[3][c*CW +: CW])),
                max2(max2(nbr[4][c*CW +: CW], nbr[5][c*CW +: CW]),
                     max2(nbr[6][c*CW +: CW], nbr[7][c*CW +: CW])));
        end
    end

    // Border pixels give zero
    assign push             = ctl.valid && ctl.emit;
    assign result.red       = ctl.interior ? best[3*CW-1:2*CW] : '0;
    assign result.green     = ctl.interior ? best[2*CW-1:CW]   : '0;
    assign result.blue      = ctl.interior ? best[CW-1:0]      : '0;
    assign result.frame_end = ctl.frame_end;

endmodule

>>> sv/rgbdil_ofifo.sv
`include "assert_macros.svh"

module rgbdil_ofifo (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    input  rgbdil_pkg::result_t              push_data,
    output logic                             pop_valid,
    input  logic                             pop_ready,
    output rgbdil_pkg::result_t              pop_data,
    output logic [rgbdil_pkg::OFIFO_AW:0]    count
);

    localparam int DEPTH = rgbdil_pkg::OFIFO_DEPTH;
    localparam int AW    = rgbdil_pkg::OFIFO_AW;

    rgbdil_pkg::result_t mem [DEPTH];
    logic [AW-1:0]       wr_ptr_reg;
    logic [AW-1:0]       rd_ptr_reg;
    logic [AW:0]         count_reg;
    logic [AW:0]         count_next;
    logic                pop;
    logic                full;
    logic                level_ok;

    assign pop       = pop_valid && pop_ready;
    assign pop_valid = (count_reg != '0);
    assign pop_data  = mem[rd_ptr_reg];
    assign count     = count_reg;
    assign full      = (count_reg == (AW+1)'(DEPTH));
    assign level_ok  = (count_reg <= (AW+1)'(DEPTH));

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    `ASSERT_CLK(a_no_overflow, (push && !pop) |-> !full, "word pushed into full output buffer")
    `ASSERT_CLK_ALWAYS(a_count_bound, !rst_n || level_ok, "output buffer level out of range")

endmodule

>>> sv/rgb_dilation_3x3_ring_core.sv
// 3x3 per-channel dilation of an RGB pixel stream, raster order.
// Input channel (in_valid/in_ready): func = 0 carries a pixel word, func = 1 is a
// flush tick. Output channel (out_valid/out_ready): one word per interior or border
// pixel, max of the eight neighbours per channel, zero on the border rows and
// columns; frame_end marks the last word of the image.
// The result of pixel k leaves with input word k + W + 1; after the last pixel,
// W + 1 flush ticks drain the remaining (border, all zero) words.
// Pixels after the image is complete and flush ticks with nothing pending are
// accepted and produce no word.
// Throughput: one word per cycle while in_ready is high. An accepted word is registered
// in the line memory stage (line RAM read), then enters the output buffer, raising out_valid.
// Config (APB): image_width at 0x0, image_height at 0x4; a write restarts the
// image. Write only while idle.
// Reset: counters and window clear, width 640, height 480; line memory is not
// cleared (unwritten entries only feed border pixels).
// A stalled receiver fills a 4-word output buffer; in_ready drops once the buffer
// and the word in flight could fill it.
`include "assert_macros.svh"

module rgb_dilation_3x3_ring_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        func,
    input  logic [7:0]  red_in,
    input  logic [7:0]  green_in,
    input  logic [7:0]  blue_in,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  red_out,
    output logic [7:0]  green_out,
    output logic [7:0]  blue_out,
    output logic        frame_end
);

    localparam int COL_W   = rgbdil_pkg::COL_W;
    localparam int EFF_W_W = rgbdil_pkg::EFF_W_W;
    localparam int IMG_W_W = rgbdil_pkg::IMG_W_W;
    localparam int IMG_H_W = rgbdil_pkg::IMG_H_W;
    localparam int PW      = rgbdil_pkg::PIX_W;
    localparam int FAW     = rgbdil_pkg::OFIFO_AW;

    logic [IMG_W_W-1:0] img_width_reg;
    logic [IMG_H_W-1:0] img_height_reg;
    logic [EFF_W_W-1:0] eff_w;
    logic [IMG_H_W-1:0] eff_h;

    logic [COL_W-1:0]   in_col_reg,  in_col_next;
    logic [IMG_H_W-1:0] in_row_reg,  in_row_next;
    logic [COL_W-1:0]   out_col_reg, out_col_next;
    logic [IMG_H_W-1:0] out_row_reg, out_row_next;

    rgbdil_pkg::s1_ctl_t s1_reg, s1_next;
    logic [COL_W-1:0]    s1_col_reg;
    logic [PW-1:0]       s1_pix_reg;

    logic                cfg_wr;
    logic                acc;
    logic                img_done;
    logic                pix_ok;
    logic                emit;
    logic                interior;
    logic                last_out;
    logic                last_col;
    logic                push;
    logic                wrap_clear;
    logic [FAW:0]        fifo_count;
    rgbdil_pkg::result_t push_data;
    rgbdil_pkg::result_t pop_data;

    // APB register file
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            img_width_reg  <= rgbdil_pkg::IMG_WIDTH_RST;
            img_height_reg <= rgbdil_pkg::IMG_HEIGHT_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                rgbdil_pkg::REG_IMG_WIDTH:  img_width_reg  <= pwdata[IMG_W_W-1:0];
                rgbdil_pkg::REG_IMG_HEIGHT: img_height_reg <= pwdata[IMG_H_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            rgbdil_pkg::REG_IMG_WIDTH:  prdata = 32'(img_width_reg);
            rgbdil_pkg::REG_IMG_HEIGHT: prdata = 32'(img_height_reg);
            default:                    prdata = '0;
        endcase
    end

    // Effective geometry: width clamped to [3, MAX_WIDTH], height to at least 3
    always_comb
    begin
        if (img_width_reg < IMG_W_W'(3))
        begin
            eff_w = EFF_W_W'(3);
        end
        else if (EFF_W_W'(img_width_reg) > EFF_W_W'(rgbdil_pkg::MAX_WIDTH))
        begin
            eff_w = EFF_W_W'(rgbdil_pkg::MAX_WIDTH);
        end
        else
        begin
            eff_w = EFF_W_W'(img_width_reg);
        end
        eff_h = (img_height_reg < IMG_H_W'(3)) ? IMG_H_W'(3) : img_height_reg;
    end

    // Accept decision and result position
    assign in_ready = (fifo_count + (FAW+1)'(s1_reg.valid)) < (FAW+1)'(rgbdil_pkg::OFIFO_DEPTH);
    assign acc      = in_valid && in_ready;
    assign img_done = (in_row_reg >= eff_h);
    assign pix_ok   = (func == rgbdil_pkg::FUNC_PIXEL) && !img_done;
    assign last_col = (EFF_W_W'(in_col_reg) + 1'b1 == eff_w);

    assign emit = acc &&
                  ((pix_ok && ((in_row_reg >= IMG_H_W'(2)) ||
                               (in_row_reg == IMG_H_W'(1) && in_col_reg != '0))) ||
                   (func == rgbdil_pkg::FUNC_FLUSH && img_done));

    assign interior = (out_row_reg != '0) && (out_row_reg <= eff_h - IMG_H_W'(2)) &&
                      (out_col_reg != '0) && (EFF_W_W'(out_col_reg) + 2'd2 <= eff_w);
    assign last_out = (out_row_reg == eff_h - 1'b1) &&
                      (EFF_W_W'(out_col_reg) + 1'b1 == eff_w);

    // Position counters
    always_comb
    begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (cfg_wr)
        begin
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
        end
        else if (acc)
        begin
            if (pix_ok)
            begin
                if (last_col)
                begin
                    in_col_next = '0;
                    in_row_next = in_row_reg + 1'b1;
                end
                else
                begin
                    in_col_next = in_col_reg + 1'b1;
                end
            end
            if (emit)
            begin
                if (last_out)
                begin
                    in_col_next  = '0;
                    in_row_next  = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                end
                else if (EFF_W_W'(out_col_reg) + 1'b1 == eff_w)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + 1'b1;
                end
                else
                begin
                    out_col_next = out_col_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else
        begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

    // Line memory stage control
    always_comb
    begin
        s1_next.valid     = acc;
        s1_next.pix_op    = pix_ok;
        s1_next.emit      = emit;
        s1_next.interior  = interior;
        s1_next.frame_end = last_out;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg <= '0;
        end
        else
        begin
            s1_reg <= s1_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s1_col_reg <= in_col_reg;
            s1_pix_reg <= {red_in, green_in, blue_in};
        end
    end

    rgbdil_window u_window (
        .clk    (clk),
        .rst_n  (rst_n),
        .clear  (cfg_wr),
        .rd_en  (acc && pix_ok),
        .rd_col (in_col_reg),
        .ctl    (s1_reg),
        .wr_col (s1_col_reg),
        .pix    (s1_pix_reg),
        .push   (push),
        .result (push_data)
    );

    rgbdil_ofifo u_ofifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop_valid (out_valid),
        .pop_ready (out_ready),
        .pop_data  (pop_data),
        .count     (fifo_count)
    );

    assign red_out   = pop_data.red;
    assign green_out = pop_data.green;
    assign blue_out  = pop_data.blue;
    assign frame_end = pop_data.frame_end;

    // All position counters back at the image start
    assign wrap_clear = (in_row_reg == '0) && (in_col_reg == '0) &&
                        (out_row_reg == '0) && (out_col_reg == '0);

    `ASSERT_CLK(a_frame_wrap, (emit && last_out) |=> wrap_clear, "counters not cleared after last word")

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    localparam int CLK_PERIOD   = 8;
    localparam int RESET_CYCLES = 7;
    localparam int DRAIN_CYCLES = 8;
    localparam int TAIL_CYCLES  = 20;
    localparam int STREAM_ITEMS = 400;
    localparam int TIMEOUT_NS   = 24_000_000;

    localparam int MAX_WIDTH = rgbdil_pkg::MAX_WIDTH;
    localparam int IMG_W_W   = rgbdil_pkg::IMG_W_W;
    localparam int IMG_H_W   = rgbdil_pkg::IMG_H_W;
    localparam int CH_W      = rgbdil_pkg::CH_W;
    localparam int PIX_W     = rgbdil_pkg::PIX_W;

    // Directed table: a word to send, or a register write between phases
    typedef enum logic [1:0] {ROW_ITEM, ROW_WIDTH, ROW_HEIGHT} row_kind_e;
    // Expected output for a row: from the predictor, none, all zero, all zero + frame_end
    typedef enum logic [1:0] {EXP_PRED, EXP_NONE, EXP_ZERO, EXP_LAST} row_exp_e;

    typedef struct packed {
        row_kind_e        kind;
        logic             fn;
        logic [PIX_W-1:0] val;
        row_exp_e         chk;
    } row_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  psel      = 1'b0;
    logic                  penable   = 1'b0;
    logic                  pwrite    = 1'b0;
    logic [2:0]            paddr     = '0;
    logic [31:0]           pwdata    = '0;
    logic [31:0]           prdata;
    logic                  pready;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    logic                  func      = rgbdil_pkg::FUNC_PIXEL;
    logic [CH_W-1:0]       red_in    = '0;
    logic [CH_W-1:0]       green_in  = '0;
    logic [CH_W-1:0]       blue_in   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [CH_W-1:0]       red_out;
    logic [CH_W-1:0]       green_out;
    logic [CH_W-1:0]       blue_out;
    logic                  frame_end;

    // Predictor state
    logic [IMG_W_W-1:0]    width_reg;
    logic [IMG_H_W-1:0]    height_reg;
    logic [PIX_W-1:0]      upper_mem  [MAX_WIDTH];
    logic [PIX_W-1:0]      middle_mem [MAX_WIDTH];
    logic [PIX_W-1:0]      win [9];
    int unsigned           col_pos;
    int unsigned           row_pos;
    int unsigned           emitted;

    rgbdil_pkg::result_t   dilated_q [$];
    int unsigned           mismatch_cnt = 0;
    int unsigned           stream_items = 0;
    int unsigned           ready_hold   = 0;
    bit                    steady       = 1'b0;

    row_t dir_rows [20] = '{
        // flush with nothing pending, then a lone pixel at the reset geometry
        '{ROW_ITEM,   rgbdil_pkg::FUNC_FLUSH, 24'h5A5A5A, EXP_NONE},
        '{ROW_ITEM,   rgbdil_pkg::FUNC_PIXEL, 24'hFFFFFF, EXP_NONE},
        // 3x3 image: only the centre is interior, centre itself is excluded
        '{ROW_WIDTH,  rgbdil_pkg::FUNC_PIXEL, 24'h000003, EXP_NONE},
        '{ROW_HEIGHT, rgbdil_pkg::FUNC_PIXEL, 24'h000003, EXP_NONE},
        '{ROW_ITEM,   rgbdil_pkg::FUNC_PIXEL, 24'h7F0000, EXP_NONE},
        '{ROW_ITEM,   rgbdil_pkg::FUNC_PIXEL, 24'h008000, EXP_NONE},
        '{ROW_ITEM,   rgbdil_pkg::FUNC_PIXEL, 24'h000001, EXP_NONE},
        '{ROW_ITEM,   rgbdil_pkg::FUNC_FLUSH, 24'hFFFFFF, EXP_NONE},
        '{ROW_ITEM,   rgbdil_pkg::FUNC_PIXEL, 24'h010101, EXP_NONE},
        '{ROW_ITEM,   rgbdil_pkg::FUNC_PIXEL, 24'hFFFFFF, EXP_ZERO},
        '{ROW_ITEM,   rgbdil_pkg::FUNC_PIXEL, 24'h000000, EXP_ZERO},
        '{ROW_ITEM,   rgbdil_pkg::FUNC_PIXEL, 24'h3F3F3F, EXP_ZERO},
        '{ROW_ITEM,   rgbdil_pkg::FUNC_PIXEL, 24'h000000, EXP_ZERO},
        '{ROW_ITEM,   rgbdil_pkg::FUNC_PIXEL, 24'h7E7F00, EXP_PRED},
        // pixel while draining is dropped; drain the bottom border
        '{ROW_ITEM,   rgbdil_pkg::FUNC_PIXEL, 24'hFFFFFF, EXP_NONE},
        '{ROW_ITEM,   rgbdil_pkg::FUNC_FLUSH, 24'h000000, EXP_ZERO},
        '{ROW_ITEM,   rgbdil_pkg::FUNC_FLUSH, 24'hFFFFFF, EXP_ZERO},
        '{ROW_ITEM,   rgbdil_pkg::FUNC_FLUSH, 24'h000000, EXP_ZERO},
        '{ROW_ITEM,   rgbdil_pkg::FUNC_FLUSH, 24'hFFFFFF, EXP_LAST},
        // frame wrapped: flush has nothing to drain
        '{ROW_ITEM,   rgbdil_pkg::FUNC_FLUSH, 24'h000000, EXP_NONE}
    };

    rgb_dilation_3x3_ring_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .func      (func),
        .red_in    (red_in),
        .green_in  (green_in),
        .blue_in   (blue_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .red_out   (red_out),
        .green_out (green_out),
        .blue_out  (blue_out),
        .frame_end (frame_end)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Geometry clamps
    function automatic int unsigned geom_w();
        int unsigned w;
        w = width_reg;
        if (w < 3) w = 3;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        return w;
    endfunction

    function automatic int unsigned geom_h();
        int unsigned h;
        h = height_reg;
        if (h < 3) h = 3;
        return h;
    endfunction

    function automatic void restart_image();
        col_pos = 0;
        row_pos = 0;
        emitted = 0;
        foreach (win[i]) win[i] = '0;
    endfunction

    // Max of one channel over the eight neighbours
    function automatic logic [CH_W-1:0] nbr_max(input int sh);
        logic [CH_W-1:0] best;
        logic [CH_W-1:0] v;
        best = '0;
        for (int i = 0; i < 9; i++) begin
            if (i == 4) continue;
            v = CH_W'(win[i] >> sh);
            if (v > best) best = v;
        end
        return best;
    endfunction

    // One input word through the dilation; returns 1 when it yields an output word
    function automatic bit dilate_step(input logic fn, input logic [PIX_W-1:0] px,
                                       output rgbdil_pkg::result_t res);
        int unsigned w, h, total, c, r, n, tr, tc;
        logic [PIX_W-1:0] top, mid, pv;
        w = geom_w();
        h = geom_h();
        total = w * h;
        res = '0;
        if (fn == rgbdil_pkg::FUNC_PIXEL) begin
            c = col_pos;
            r = row_pos;
            if (r >= h || c >= w) return 1'b0;
            top = upper_mem[c];
            mid = middle_mem[c];
            upper_mem[c] = mid;
            middle_mem[c] = px;
            for (int k = 0; k < 3; k++) begin
                win[k*3]     = win[k*3 + 1];
                win[k*3 + 1] = win[k*3 + 2];
            end
            win[2] = top;
            win[5] = mid;
            win[8] = px;
            n = r * w + c;
            if (c + 1 >= w) begin
                col_pos = 0;
                row_pos = r + 1;
            end else begin
                col_pos = c + 1;
            end
            if (n < w + 1) return 1'b0;
            // window centre trails the incoming pixel by one row and one column
            if (c >= 1) begin
                tr = r - 1;
                tc = c - 1;
            end else begin
                tr = r - 2;
                tc = w - 1;
            end
            if (tr >= 1 && tr + 2 <= h && tc >= 1 && tc + 2 <= w)
                pv = {nbr_max(16), nbr_max(8), nbr_max(0)};
            else
                pv = '0;
        end else begin
            if (row_pos < h || emitted >= total) return 1'b0;
            pv = '0;
        end
        res.red       = pv[23:16];
        res.green     = pv[15:8];
        res.blue      = pv[7:0];
        res.frame_end = (emitted == total - 1);
        emitted++;
        if (emitted >= total) begin
            col_pos = 0;
            row_pos = 0;
            emitted = 0;
        end
        return 1'b1;
    endfunction

    // Idle length: mostly none, some short, a few long
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 10);
        return $urandom_range(15, 30);
    endfunction

    function automatic logic [CH_W-1:0] pick_chan();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return CH_W'($urandom());
    endfunction

    function automatic logic [PIX_W-1:0] pick_px();
        return {pick_chan(), pick_chan(), pick_chan()};
    endfunction

    task automatic note_fail(input string msg);
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("%0t: %s", $realtime, msg);
    endtask

    // Send one word; the predictor steps at the accepting edge
    task automatic send_word(input logic fn, input logic [PIX_W-1:0] px, input row_exp_e chk);
        rgbdil_pkg::result_t pred;
        rgbdil_pkg::result_t fixed;
        bit                  has;
        int unsigned         gap;
        in_valid <= 1'b1;
        func     <= fn;
        red_in   <= px[23:16];
        green_in <= px[15:8];
        blue_in  <= px[7:0];
        do @(posedge clk); while (!in_ready);
        has = dilate_step(fn, px, pred);
        fixed = '0;
        case (chk)
            EXP_PRED: if (has) dilated_q.push_back(pred);
            EXP_ZERO: dilated_q.push_back(fixed);
            EXP_LAST:
            begin
                fixed.frame_end = 1'b1;
                dilated_q.push_back(fixed);
            end
            default: ;
        endcase
        gap = pick_gap();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Register write once idle, then read it back
    task automatic reg_write(input logic sel, input int unsigned code);
        logic [31:0] wdata;
        logic [31:0] want_rd;
        in_valid <= 1'b0;
        while (dilated_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        wdata = $urandom();
        if (sel == rgbdil_pkg::REG_IMG_WIDTH)
        begin
            wdata[IMG_W_W-1:0] = IMG_W_W'(code);
            want_rd = {{(32-IMG_W_W){1'b0}}, wdata[IMG_W_W-1:0]};
        end
        else
        begin
            wdata[IMG_H_W-1:0] = IMG_H_W'(code);
            want_rd = {{(32-IMG_H_W){1'b0}}, wdata[IMG_H_W-1:0]};
        end
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        // write lands here; go straight into the read setup
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (sel == rgbdil_pkg::REG_IMG_WIDTH)
            width_reg = wdata[IMG_W_W-1:0];
        else
            height_reg = wdata[IMG_H_W-1:0];
        restart_image();
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== want_rd)
            note_fail($sformatf("register %0d readback: expected %08h, got %08h",
                                sel, want_rd, prdata));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // One image at the current geometry, optionally cut short with noise mixed in
    task automatic send_frame(input bit may_abort, output bit aborted);
        int unsigned total, stop, w;
        w = geom_w();
        total = w * geom_h();
        stop = total;
        aborted = 1'b0;
        if (may_abort && $urandom_range(0, 9) == 0)
        begin
            stop = $urandom_range(1, total - 1);
            aborted = 1'b1;
        end
        for (int unsigned k = 0; k < stop; k++)
        begin
            if (may_abort && $urandom_range(0, 39) == 0)
                send_word(rgbdil_pkg::FUNC_FLUSH, pick_px(), EXP_PRED);
            send_word(rgbdil_pkg::FUNC_PIXEL, pick_px(), EXP_PRED);
            stream_items++;
        end
        if (aborted) return;
        for (int unsigned k = 0; k <= w; k++)
        begin
            if (may_abort && $urandom_range(0, 19) == 0)
                send_word(rgbdil_pkg::FUNC_PIXEL, pick_px(), EXP_PRED);
            send_word(rgbdil_pkg::FUNC_FLUSH, pick_px(), EXP_PRED);
            stream_items++;
        end
    endtask

    // Receiver: random stalls
    always @(posedge clk)
    begin
        if (ready_hold != 0)
            ready_hold <= ready_hold - 1;
        else
        begin
            out_ready  <= steady || ($urandom_range(0, 2) != 0);
            ready_hold <= pick_gap();
        end
    end

    // Output check against the oldest expected word
    always @(posedge clk)
    begin : word_check
        rgbdil_pkg::result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (dilated_q.size() == 0)
                note_fail($sformatf("unexpected word r=%02h g=%02h b=%02h end=%0b",
                                    red_out, green_out, blue_out, frame_end));
            else
            begin
                want = dilated_q.pop_front();
                if (red_out !== want.red || green_out !== want.green ||
                    blue_out !== want.blue || frame_end !== want.frame_end)
                    note_fail($sformatf(
                        "word mismatch: exp %02h%02h%02h end=%0b, got %02h%02h%02h end=%0b",
                        want.red, want.green, want.blue, want.frame_end,
                        red_out, green_out, blue_out, frame_end));
            end
        end
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("rgb_dilation_3x3_ring_core test failed");
        $finish;
    end

    initial
    begin
        int unsigned w_code, h_code, frames, r;
        bit          aborted;

        width_reg  = rgbdil_pkg::IMG_WIDTH_RST;
        height_reg = rgbdil_pkg::IMG_HEIGHT_RST;
        foreach (upper_mem[i]) upper_mem[i] = '0;
        foreach (middle_mem[i]) middle_mem[i] = '0;
        restart_image();

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        foreach (dir_rows[i])
        begin
            case (dir_rows[i].kind)
                ROW_ITEM:   send_word(dir_rows[i].fn, dir_rows[i].val, dir_rows[i].chk);
                ROW_WIDTH:  reg_write(rgbdil_pkg::REG_IMG_WIDTH, 32'(dir_rows[i].val));
                ROW_HEIGHT: reg_write(rgbdil_pkg::REG_IMG_HEIGHT, 32'(dir_rows[i].val));
                default: ;
            endcase
        end

        // Widest image: width code above range and height below both clamp;
        // run past the last column into the second row, cut short by the next write
        reg_write(rgbdil_pkg::REG_IMG_WIDTH, 2047);
        reg_write(rgbdil_pkg::REG_IMG_HEIGHT, 0);
        for (int k = 0; k < MAX_WIDTH + 4; k++)
            send_word(rgbdil_pkg::FUNC_PIXEL, pick_px(), EXP_PRED);

        // Tallest height at the max and min width codes, cut short by the next write
        reg_write(rgbdil_pkg::REG_IMG_WIDTH, MAX_WIDTH);
        reg_write(rgbdil_pkg::REG_IMG_HEIGHT, 65535);
        reg_write(rgbdil_pkg::REG_IMG_WIDTH, 0);
        for (int k = 0; k < 60; k++)
            send_word(rgbdil_pkg::FUNC_PIXEL, pick_px(), EXP_PRED);

        // Random images, mostly small, a few frames back to back per setting
        stream_items = 0;
        while (stream_items < STREAM_ITEMS)
        begin
            steady = ($urandom_range(0, 4) == 0);
            r = $urandom_range(0, 19);
            if (r == 0)
                w_code = $urandom_range(0, 2);
            else if (r < 3)
                w_code = $urandom_range(13, 40);
            else
                w_code = $urandom_range(3, 12);
            r = $urandom_range(0, 19);
            if (r < 2)
                h_code = $urandom_range(0, 2);
            else if (r == 2)
                h_code = $urandom_range(9, 12);
            else
                h_code = $urandom_range(3, 8);
            reg_write(rgbdil_pkg::REG_IMG_WIDTH, w_code);
            reg_write(rgbdil_pkg::REG_IMG_HEIGHT, h_code);
            frames = $urandom_range(1, 3);
            for (int unsigned fr = 0; fr < frames; fr++)
            begin
                send_frame(1'b1, aborted);
                if (aborted) break;
            end
        end
        steady = 1'b0;

        // Drain and settle
        in_valid <= 1'b0;
        while (dilated_q.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_cnt == 0)
            $display("rgb_dilation_3x3_ring_core test passed");
        else
            $display("rgb_dilation_3x3_ring_core test failed");
        $finish;
    end

endmodule
